@@ design/rmt_pkg.sv @@
package rmt_pkg;

  // Sequencer states of the heap engine
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_CMP,
    ST_REBAL,
    ST_POP_LAST,
    ST_POP,
    ST_POP_R,
    ST_POP_CMP,
    ST_DONE
  } rmt_state_e;

  // Handshake status from the engine to the stream side
  typedef struct packed {
    logic idle;
    logic done;
  } rmt_stat_t;

  // Register byte addresses
  localparam logic [1:0] AddrEnable = 2'd0;

endpackage

@@ design/running_median_tracker_top.sv @@
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: sample_value[15:0]
// m_axis    out  tdata: median_doubled[16:0], held_count[27:17], zero[31:28];
//                tuser: median_valid[0], store_full[1]
// apb       in   register 0 at byte 0: tracking_enable[0]
// A request sifts the sample up its heap level by level; on a rebalance it then sifts
// down the heap that gave up its top and sifts that top up into the other heap. The pace
// is set by the single read port of each heap memory and the one shared comparator.
// s_axis_tready is high only while the sequencer idles; the result register lets the
// next request start while m_axis is stalled. Reset clears heap sizes and the enable,
// not the memories.
module running_median_tracker_top #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // median_doubled, held_count, zero pad
  output logic [1:0]  m_axis_tuser,   // median_valid, store_full
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmt_pkg::*;

  rmt_stat_t             stat;
  logic                  en_q;
  logic                  ovalid_q, ovalid_d, res_ready, take;
  logic [VALUE_BITS:0]   median;
  logic [10:0]           count;
  logic                  mvalid, full;
  logic [31:0]           tdata_q;
  logic [1:0]            tuser_q;
  logic [VALUE_BITS-1:0] value;

  assign value = VALUE_BITS'(s_axis_tdata);

  // Register write, always ready
  assign pready = 1'b1;
  assign prdata = {31'b0, en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == AddrEnable) begin
      en_q <= pwdata[0];
    end
  end

  rmt_engine #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_engine (
    .clk_i, .rst_ni,
    .start_i(s_axis_tvalid && s_axis_tready),
    .value_i(value),
    .enable_i(en_q),
    .res_ready_i(res_ready),
    .stat_o(stat),
    .median_o(median),
    .count_o(count),
    .valid_o(mvalid),
    .full_o(full)
  );

  assign s_axis_tready = stat.idle;

  // Hand the finished request to the output register
  assign res_ready = !ovalid_q || m_axis_tready;
  assign take      = stat.done && res_ready;

  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tready) ovalid_d = 1'b0;
    if (take)          ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else         ovalid_q <= ovalid_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tdata_q <= {4'b0, count, 17'(median)};
      tuser_q <= {full, mvalid};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

@@ design/rmt_heap_ram.sv @@
module rmt_heap_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 513,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/rmt_cmp.sv @@
module rmt_cmp #(
  parameter int DW = 16
) (
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic          is_max_i,
  output logic          above_o
);

  // a ranks above b: larger in a max-heap, smaller in a min-heap
  assign above_o = is_max_i ? (a_i > b_i) : (a_i < b_i);

endmodule

@@ design/rmt_engine.sv @@
module rmt_engine #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   value_i,
  input  logic                    enable_i,
  input  logic                    res_ready_i,
  output rmt_pkg::rmt_stat_t      stat_o,
  output logic [VALUE_BITS:0]     median_o,
  output logic [10:0]             count_o,
  output logic                    valid_o,
  output logic                    full_o
);
  import rmt_pkg::*;

  localparam int DEPTH = (CAPACITY + 1) / 2 + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SZW   = $clog2(DEPTH + 1);
  localparam int CW    = AW + 2;
  localparam int VB    = VALUE_BITS;

  rmt_state_e state_q, state_d;

  logic [SZW-1:0] lsize_q, lsize_d, usize_q, usize_d, n_q, n_d;
  logic           upper_q, upper_d;    // heap under work: 1 = upper (min) heap
  logic           insert_q, insert_d;  // pushing the new sample, not a moved top
  logic           full_q, full_d;
  logic           rv_q, rv_d;          // right child exists
  logic [AW-1:0]  pos_q, pos_d, best_q, best_d;
  logic [VB-1:0]  hv_q, hv_d, mv_q, mv_d, cand_q, cand_d;
  logic [VB-1:0]  ltop_q, ltop_d, utop_q, utop_d;

  // Memory and compare unit controls
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [VB-1:0]  wdata, rdata, rdata_l, rdata_u;
  logic [VB-1:0]  ca, cb;
  logic           is_max, above;

  logic [SZW:0]   held;
  logic           cap_hit;
  logic [CW-1:0]  lidx, ridx;
  logic [AW-1:0]  parent;
  logic           l_ok, r_ok, r_take;
  logic [SZW-1:0] oth_size;
  logic           rebal;
  logic [SZW-1:0] pop_size;

  rmt_heap_ram #(.DW(VB), .DEPTH(DEPTH), .AW(AW)) u_lower (
    .clk_i, .we_i(we && !upper_q), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata_l)
  );

  rmt_heap_ram #(.DW(VB), .DEPTH(DEPTH), .AW(AW)) u_upper (
    .clk_i, .we_i(we && upper_q), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata_u)
  );

  rmt_cmp #(.DW(VB)) u_cmp (.a_i(ca), .b_i(cb), .is_max_i(is_max), .above_o(above));

  assign rdata    = upper_q ? rdata_u : rdata_l;
  assign held     = {1'b0, lsize_q} + {1'b0, usize_q};
  assign cap_hit  = 32'(held) >= CAPACITY;
  assign lidx     = {1'b0, pos_q, 1'b1};
  assign ridx     = lidx + CW'(1);
  assign l_ok     = lidx < CW'(n_q);
  assign r_ok     = ridx < CW'(n_q);
  assign parent   = AW'((pos_q - AW'(1)) >> 1);
  assign r_take   = rv_q && above;
  assign oth_size = upper_q ? lsize_q : usize_q;

  // Rebalance when the lower heap leads by two or the upper heap leads
  assign rebal    = ({1'b0, lsize_q} > {1'b0, usize_q} + (SZW+1)'(1)) ||
                    (usize_q > lsize_q);
  assign pop_size = (lsize_q > usize_q) ? lsize_q : usize_q;

  // Feed the shared compare unit
  always_comb begin
    ca     = hv_q;
    cb     = rdata;
    is_max = !upper_q;
    case (state_q)
      ST_IDLE: begin
        ca     = value_i;
        cb     = ltop_q;
        is_max = 1'b1;
      end
      ST_POP_R: begin
        ca = rdata;
        cb = hv_q;
      end
      ST_POP_CMP: begin
        ca = rdata;
        cb = cand_q;
      end
      default: begin
        ca = hv_q;
        cb = rdata;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (enable_i && !cap_hit) ? ST_PUSH : ST_DONE;
        end
      end
      ST_PUSH: begin
        if (pos_q == '0) begin
          state_d = insert_q ? ST_REBAL : ST_DONE;
        end else begin
          state_d = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        if (above) state_d = ST_PUSH;
        else       state_d = insert_q ? ST_REBAL : ST_DONE;
      end
      ST_REBAL: begin
        if (rebal) begin
          state_d = (pop_size == SZW'(1)) ? ST_PUSH : ST_POP_LAST;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP_LAST: state_d = ST_POP;
      ST_POP:      state_d = l_ok ? ST_POP_R : ST_PUSH;
      ST_POP_R:    state_d = ST_POP_CMP;
      ST_POP_CMP: begin
        if (!r_take && best_q == pos_q) state_d = ST_PUSH;
        else                            state_d = ST_POP;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    logic         pop_lower;
    logic [AW-1:0] b;
    logic [VB-1:0] c;
    lsize_d  = lsize_q;
    usize_d  = usize_q;
    n_d      = n_q;
    upper_d  = upper_q;
    insert_d = insert_q;
    full_d   = full_q;
    rv_d     = rv_q;
    pos_d    = pos_q;
    best_d   = best_q;
    hv_d     = hv_q;
    mv_d     = mv_q;
    cand_d   = cand_q;
    ltop_d   = ltop_q;
    utop_d   = utop_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = hv_q;
    raddr    = parent;
    pop_lower = lsize_q > usize_q;
    b        = best_q;
    c        = cand_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          full_d   = enable_i && cap_hit;
          insert_d = 1'b1;
          hv_d     = value_i;
          if (enable_i && !cap_hit) begin
            if (lsize_q == '0 || !above) begin
              upper_d = 1'b0;
              pos_d   = AW'(lsize_q);
              lsize_d = lsize_q + SZW'(1);
            end else begin
              upper_d = 1'b1;
              pos_d   = AW'(usize_q);
              usize_d = usize_q + SZW'(1);
            end
          end
        end
      end
      ST_PUSH: begin
        // Settle at the root, else fetch the parent
        if (pos_q == '0) we = 1'b1;
        raddr = parent;
      end
      ST_PUSH_CMP: begin
        // Move the parent down or drop the value into the hole
        we = 1'b1;
        if (above) begin
          wdata = rdata;
          pos_d = parent;
        end
      end
      ST_REBAL: begin
        // Take the top of the larger heap
        if (rebal) begin
          insert_d = 1'b0;
          upper_d  = !pop_lower;
          mv_d     = pop_lower ? ltop_q : utop_q;
          hv_d     = pop_lower ? ltop_q : utop_q;
          n_d      = (pop_lower ? lsize_q : usize_q) - SZW'(1);
          raddr    = AW'((pop_lower ? lsize_q : usize_q) - SZW'(1));
          if (pop_lower) lsize_d = lsize_q - SZW'(1);
          else           usize_d = usize_q - SZW'(1);
          if ((pop_lower ? lsize_q : usize_q) == SZW'(1)) begin
            // Heap becomes empty: push the top straight to the other side
            upper_d = pop_lower;
            pos_d   = AW'(pop_lower ? usize_q : lsize_q);
            if (pop_lower) usize_d = usize_q + SZW'(1);
            else           lsize_d = lsize_q + SZW'(1);
          end
        end
      end
      ST_POP_LAST: begin
        pos_d = '0;
      end
      ST_POP: begin
        // Last element sits in hv; hole at pos
        if (!l_ok) hv_d = rdata;
        raddr = AW'(lidx);
      end
      ST_POP_R: begin
        raddr  = AW'(ridx);
        rv_d   = r_ok;
        best_d = above ? AW'(lidx) : pos_q;
        cand_d = above ? rdata : hv_q;
      end
      ST_POP_CMP: begin
        if (r_take) begin
          b = AW'(ridx);
          c = rdata;
        end
        we = 1'b1;
        if (b == pos_q) begin
          wdata = hv_q;
        end else begin
          wdata = c;
          pos_d = b;
        end
      end
      default: ;
    endcase

    // Keep the hole value from the last element after its read
    if (state_q == ST_POP_LAST) hv_d = rdata;

    // End of pop: push the moved top into the other heap
    if ((state_q == ST_POP && !l_ok) ||
        (state_q == ST_POP_CMP && !r_take && best_q == pos_q)) begin
      if (state_q == ST_POP) begin
        we    = 1'b1;
        wdata = hv_q;
      end
      hv_d    = mv_q;
      upper_d = !upper_q;
      pos_d   = AW'(oth_size);
      if (upper_q) lsize_d = lsize_q + SZW'(1);
      else         usize_d = usize_q + SZW'(1);
    end

    // Track the roots
    if (we && waddr == '0) begin
      if (upper_q) utop_d = wdata;
      else         ltop_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lsize_q  <= '0;
      usize_q  <= '0;
      n_q      <= '0;
      upper_q  <= 1'b0;
      insert_q <= 1'b0;
      full_q   <= 1'b0;
      rv_q     <= 1'b0;
      pos_q    <= '0;
      best_q   <= '0;
    end else begin
      state_q  <= state_d;
      lsize_q  <= lsize_d;
      usize_q  <= usize_d;
      n_q      <= n_d;
      upper_q  <= upper_d;
      insert_q <= insert_d;
      full_q   <= full_d;
      rv_q     <= rv_d;
      pos_q    <= pos_d;
      best_q   <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hv_q   <= hv_d;
    mv_q   <= mv_d;
    cand_q <= cand_d;
    ltop_q <= ltop_d;
    utop_q <= utop_d;
  end

  // Result from the settled heaps
  always_comb begin
    median_o = '0;
    if (lsize_q != '0) begin
      if (lsize_q == usize_q) median_o = {1'b0, ltop_q} + {1'b0, utop_q};
      else                    median_o = {ltop_q, 1'b0};
    end
  end

  assign count_o     = 11'(held);
  assign valid_o     = lsize_q != '0;
  assign full_o      = full_q;
  assign stat_o.idle = state_q == ST_IDLE;
  assign stat_o.done = state_q == ST_DONE;

endmodule
